// File: rtl/wlc_pkg.sv
`default_nettype none
package wlc_pkg;

  localparam int DIST_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NODE_BITS   = 24;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int SUM_W       = DIST_BITS + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int REGION_W    = 3;
  localparam int LAYER_W     = 2;
  localparam int STATUS_W    = 2;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  localparam logic [FRAC_W-1:0] EPI_FRAC_RST  = FRAC_W'(21845);
  localparam logic [FRAC_W-1:0] ENDO_FRAC_RST = FRAC_W'(21845);

  typedef enum logic [REGION_W-1:0] {
    REGION_LV_WALL    = 3'd0,
    REGION_RV_WALL    = 3'd1,
    REGION_SEPTUM_L   = 3'd2,
    REGION_SEPTUM_R   = 3'd3,
    REGION_NONE       = 3'd4
  } region_e;

  typedef enum logic [LAYER_W-1:0] {
    LAYER_EPI  = 2'd0,
    LAYER_MID  = 2'd1,
    LAYER_ENDO = 2'd2
  } layer_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FRAC_OVF  = 2'd1,
    STATUS_ZERO_WALL = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THREE_SURF = 2'd0,
    CFG_EPI_FRAC   = 2'd1,
    CFG_ENDO_FRAC  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              three_surfaces;
    logic [FRAC_W-1:0] epi_fraction;
    logic [FRAC_W-1:0] endo_fraction;
  } cfg_t;

  // Payload carried through the divider stages.
  typedef struct packed {
    logic [NODE_BITS-1:0] node;
    region_e              region;
    logic                 zero;
    logic                 full;
    logic [SUM_W-1:0]     den;
    logic [SUM_W-1:0]     rem;
    logic [FRAC_BITS-1:0] quo;
  } div_t;

endpackage
`default_nettype wire

// File: rtl/wlc_if.sv
`default_nettype none
interface wlc_in_if;
  logic                          valid;
  logic                          ready;
  logic [wlc_pkg::NODE_BITS-1:0] node_index;
  logic [wlc_pkg::DIST_BITS-1:0] dist_outer;
  logic [wlc_pkg::DIST_BITS-1:0] dist_left;
  logic [wlc_pkg::DIST_BITS-1:0] dist_right;
  logic [wlc_pkg::DIST_BITS-1:0] dist_inner;

  modport source (output valid, node_index, dist_outer, dist_left, dist_right, dist_inner,
                  input ready);
  modport sink   (input valid, node_index, dist_outer, dist_left, dist_right, dist_inner,
                  output ready);
endinterface

interface wlc_out_if;
  logic                          valid;
  logic                          ready;
  logic [wlc_pkg::NODE_BITS-1:0] node_out;
  logic [wlc_pkg::REGION_W-1:0]  region;
  logic [wlc_pkg::LAYER_W-1:0]   layer;
  logic [wlc_pkg::FRAC_W-1:0]    wall_position;
  logic [wlc_pkg::STATUS_W-1:0]  status;

  modport source (output valid, node_out, region, layer, wall_position, status,
                  input ready);
  modport sink   (input valid, node_out, region, layer, wall_position, status,
                  output ready);
endinterface

interface wlc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wlc_pkg::CFG_IDX_W-1:0] index;
  logic [wlc_pkg::FRAC_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/wlc_front.sv
`default_nettype none
module wlc_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire logic         three_surf_i,
  input  wire logic         valid_i,
  input  wire logic [wlc_pkg::NODE_BITS-1:0] node_i,
  input  wire logic [wlc_pkg::DIST_BITS-1:0] epi_i,
  input  wire logic [wlc_pkg::DIST_BITS-1:0] lv_i,
  input  wire logic [wlc_pkg::DIST_BITS-1:0] rv_i,
  input  wire logic [wlc_pkg::DIST_BITS-1:0] inner_i,
  output logic              valid_o,
  output wlc_pkg::div_t     data_o
);

  wlc_pkg::region_e region_d, region_q;
  logic [wlc_pkg::DIST_BITS-1:0] endo_d, endo_q, epi_q;
  logic [wlc_pkg::NODE_BITS-1:0] node_q;
  logic a_valid_q;
  logic b_valid_q;
  wlc_pkg::div_t b_data_d, b_data_q;
  logic [wlc_pkg::SUM_W-1:0] sum;

  // Septum split: 3*lv < 2*(lv+rv) reduces to lv < 2*rv.
  always_comb begin
    if (!three_surf_i) begin
      region_d = wlc_pkg::REGION_NONE;
    end else if (rv_i >= epi_i && rv_i >= lv_i) begin
      region_d = wlc_pkg::REGION_LV_WALL;
    end else if (lv_i >= epi_i && lv_i >= rv_i) begin
      region_d = wlc_pkg::REGION_RV_WALL;
    end else if ({1'b0, lv_i} < {rv_i, 1'b0}) begin
      region_d = wlc_pkg::REGION_SEPTUM_L;
    end else begin
      region_d = wlc_pkg::REGION_SEPTUM_R;
    end
    case (region_d) inside
      wlc_pkg::REGION_NONE:                            endo_d = inner_i;
      wlc_pkg::REGION_LV_WALL, wlc_pkg::REGION_SEPTUM_L: endo_d = lv_i;
      default:                                         endo_d = rv_i;
    endcase
  end

  always_comb begin
    sum             = {1'b0, endo_q} + {1'b0, epi_q};
    b_data_d.node   = node_q;
    b_data_d.region = region_q;
    b_data_d.zero   = (sum == '0);
    b_data_d.full   = (epi_q == '0);
    b_data_d.den    = sum;
    b_data_d.rem    = {1'b0, endo_q};
    b_data_d.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      region_q <= region_d;
      endo_q   <= endo_d;
      epi_q    <= epi_i;
      node_q   <= node_i;
      b_data_q <= b_data_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_data_q;

endmodule
`default_nettype wire

// File: rtl/wlc_div_stage.sv
`default_nettype none
module wlc_div_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire wlc_pkg::div_t data_i,
  output logic               valid_o,
  output wlc_pkg::div_t      data_o
);

  logic [wlc_pkg::SUM_W:0] shifted;
  logic [wlc_pkg::SUM_W:0] diff;
  logic                    take;
  wlc_pkg::div_t           data_d, data_q;
  logic                    valid_q;

  // One restoring-division step: shift, compare, subtract.
  always_comb begin
    shifted = {data_i.rem, 1'b0};
    diff    = shifted - {1'b0, data_i.den};
    take    = (shifted >= {1'b0, data_i.den});
    data_d      = data_i;
    data_d.rem  = take ? diff[wlc_pkg::SUM_W-1:0] : shifted[wlc_pkg::SUM_W-1:0];
    data_d.quo  = {data_i.quo[wlc_pkg::FRAC_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// File: rtl/wlc_back.sv
`default_nettype none
module wlc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire wlc_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  input  wire wlc_pkg::div_t data_i,
  wlc_out_if.source          res_o
);

  logic [wlc_pkg::FRAC_W-1:0] pos;
  logic [wlc_pkg::FRAC_W:0]   frac_sum;
  logic                       frac_ovf;
  wlc_pkg::layer_e            layer_d;
  wlc_pkg::status_e           status_d;
  logic                       valid_q;
  logic [wlc_pkg::NODE_BITS-1:0] node_q;
  wlc_pkg::region_e           region_q;
  wlc_pkg::layer_e            layer_q;
  logic [wlc_pkg::FRAC_W-1:0] pos_q;
  wlc_pkg::status_e           status_q;

  always_comb begin
    if (data_i.zero) begin
      pos = '0;
    end else if (data_i.full) begin
      pos = wlc_pkg::FRAC_ONE;
    end else begin
      pos = {1'b0, data_i.quo};
    end

    frac_sum = {1'b0, cfg_i.epi_fraction} + {1'b0, cfg_i.endo_fraction};
    frac_ovf = (frac_sum > {1'b0, wlc_pkg::FRAC_ONE});

    if (pos < cfg_i.endo_fraction) begin
      layer_d = wlc_pkg::LAYER_ENDO;
    end else if (cfg_i.epi_fraction <= wlc_pkg::FRAC_ONE &&
                 pos < (wlc_pkg::FRAC_ONE - cfg_i.epi_fraction)) begin
      layer_d = wlc_pkg::LAYER_MID;
    end else begin
      layer_d = wlc_pkg::LAYER_EPI;
    end

    status_d = data_i.zero ? wlc_pkg::STATUS_ZERO_WALL : wlc_pkg::STATUS_OK;
    // Bad fractions override the status and the layer.
    if (frac_ovf) begin
      status_d = wlc_pkg::STATUS_FRAC_OVF;
      layer_d  = wlc_pkg::LAYER_EPI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      node_q   <= data_i.node;
      region_q <= data_i.region;
      layer_q  <= layer_d;
      pos_q    <= pos;
      status_q <= status_d;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.node_out      = node_q;
  assign res_o.region        = region_q;
  assign res_o.layer         = layer_q;
  assign res_o.wall_position = pos_q;
  assign res_o.status        = status_q;

endmodule
`default_nettype wire

// File: rtl/wall_layer_classifier_core.sv
`default_nettype none
// Channel | Dir | Modport | Contents
// in_i    | in  | sink    | node_index, dist_outer/left/right/inner
// res_o   | out | source  | node_out, region, layer, wall_position, status
// cfg_i   | in  | sink    | index (0 three_surfaces, 1 epi_fraction, 2 endo_fraction), data
//
// One request enters per cycle unless res_o stalls; each request passes through
// two front stages (classify, sum), one restoring-division stage per fraction bit,
// and the output register. Reset clears all valid bits and loads the register
// defaults. A stall on res_o freezes every stage at once; in_i.ready follows it.
// Config writes are always taken.
module wall_layer_classifier_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wlc_in_if.sink      in_i,
  wlc_out_if.source   res_o,
  wlc_cfg_if.sink     cfg_i
);

  wlc_pkg::cfg_t cfg_q;
  logic          adv;
  logic          stg_valid [wlc_pkg::FRAC_BITS+1];
  wlc_pkg::div_t stg_data  [wlc_pkg::FRAC_BITS+1];

  assign adv         = !res_o.valid || res_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.three_surfaces <= 1'b1;
      cfg_q.epi_fraction   <= wlc_pkg::EPI_FRAC_RST;
      cfg_q.endo_fraction  <= wlc_pkg::ENDO_FRAC_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        wlc_pkg::CFG_THREE_SURF: cfg_q.three_surfaces <= cfg_i.data[0];
        wlc_pkg::CFG_EPI_FRAC:   cfg_q.epi_fraction   <= cfg_i.data;
        wlc_pkg::CFG_ENDO_FRAC:  cfg_q.endo_fraction  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  wlc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .three_surf_i (cfg_q.three_surfaces),
    .valid_i      (in_i.valid),
    .node_i       (in_i.node_index),
    .epi_i        (in_i.dist_outer),
    .lv_i         (in_i.dist_left),
    .rv_i         (in_i.dist_right),
    .inner_i      (in_i.dist_inner),
    .valid_o      (stg_valid[0]),
    .data_o       (stg_data[0])
  );

  for (genvar i = 0; i < wlc_pkg::FRAC_BITS; i++) begin : g_div
    wlc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (stg_valid[i]),
      .data_i  (stg_data[i]),
      .valid_o (stg_valid[i+1]),
      .data_o  (stg_data[i+1])
    );
  end

  wlc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg_q),
    .valid_i (stg_valid[wlc_pkg::FRAC_BITS]),
    .data_i  (stg_data[wlc_pkg::FRAC_BITS]),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire
